// ----- design/hsn_pkg.sv -----
`timescale 1ns / 1ps

package hsn_pkg;

    localparam int DEPTH     = 64;
    localparam int PAGE_BITS = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [2:0] {
        K_VISIT      = 3'd0,
        K_FORWARD    = 3'd1,
        K_BACK       = 3'd2,
        K_LIST_BACK  = 3'd3,
        K_LIST_FWD   = 3'd4,
        K_READ       = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP,
        STK_ROT,
        STK_CLEAR
    } stk_op_t;

    typedef struct packed {
        stk_op_t op;
    } stk_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

    function automatic page_t to_page(input logic [15:0] p);
        return page_t'(p);
    endfunction

    function automatic logic [15:0] to_value(input page_t p);
        return 16'(p);
    endfunction

endpackage

// ----- design/hsn_req_if.sv -----
`timescale 1ns / 1ps

interface hsn_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] page;

    modport source (output valid, output kind, output page, input ready);
    modport sink   (input valid, input kind, input page, output ready);
endinterface

// ----- design/hsn_rsp_if.sv -----
`timescale 1ns / 1ps

interface hsn_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] value;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output value, output status, output last, input ready);
    modport sink   (input valid, input value, input status, input last, output ready);
endinterface

// ----- design/hsn_cell.sv -----
`timescale 1ns / 1ps

module hsn_cell (
    input  logic             clk,
    input  hsn_pkg::stk_op_t op,
    input  hsn_pkg::page_t   hi_q,
    input  hsn_pkg::page_t   lo_q,
    input  hsn_pkg::page_t   wrap_q,
    input  logic             is_tail,
    output hsn_pkg::page_t   q
);
    import hsn_pkg::*;

    page_t q_reg;
    page_t q_next;

    always_comb
    begin
        case (op)
            STK_PUSH: q_next = hi_q;
            STK_POP:  q_next = lo_q;
            STK_ROT:  q_next = is_tail ? wrap_q : lo_q;
            default:  q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;
endmodule

// ----- design/hsn_stack.sv -----
`timescale 1ns / 1ps

module hsn_stack (
    input  logic              clk,
    input  logic              rst_n,
    input  hsn_pkg::stk_ctrl_t ctrl,
    input  hsn_pkg::page_t    push_data,
    output hsn_pkg::page_t    top,
    output hsn_pkg::cnt_t     count
);
    import hsn_pkg::*;

    page_t q [DEPTH];
    cnt_t  count_reg;
    cnt_t  count_next;

    // cell 0 is the top; push shifts toward the bottom, pop toward the top,
    // rotate moves the top around to the deepest occupied cell
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        page_t hi;
        page_t lo;
        logic  tail;

        if (i == 0)
        begin : g_first
            assign hi = push_data;
        end
        else
        begin : g_mid
            assign hi = q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign lo = '0;
        end
        else
        begin : g_body
            assign lo = q[i+1];
        end

        assign tail = (count_reg == CNT_W'(i + 1));

        hsn_cell u_cell (
            .clk     (clk),
            .op      (ctrl.op),
            .hi_q    (hi),
            .lo_q    (lo),
            .wrap_q  (q[0]),
            .is_tail (tail),
            .q       (q[i])
        );
    end

    always_comb
    begin
        case (ctrl.op)
            STK_PUSH:  count_next = count_reg + 1'b1;
            STK_POP:   count_next = count_reg - 1'b1;
            STK_CLEAR: count_next = '0;
            default:   count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign top   = q[0];
    assign count = count_reg;
endmodule

// ----- design/two_stack_history_navigator_unit.sv -----
`timescale 1ns / 1ps

// Back/forward history navigator built from two stacks of shifting cells.
//
// Channels: req carries one request (kind, page); rsp carries result items
// (value, status, last). Both use valid/ready; a transfer happens on a rising
// edge with valid and ready high.
//
// Visit, back, forward and read current give one registered result; these
// requests can be taken every cycle while rsp drains. Listing n entries gives
// n results: the state register enters the listing state, then the output
// register takes one per cycle while rsp drains; no request is taken until
// the final one is in the output register. The cell chain rotates its top
// entry to the bottom of the occupied part for each result, so it is back in
// order when the listing ends. An empty listing gives one empty-status result
// in the cycle after the request. Kind codes six and seven are dropped.
//
// Reset clears the current page, both stack counts and the output valid flag.
// When rsp stalls, the output register holds its result and req.ready drops.
module two_stack_history_navigator_unit (
    input  logic          clk,
    input  logic          rst_n,
    hsn_req_if.sink       req,
    hsn_rsp_if.source     rsp
);
    import hsn_pkg::*;

    state_t    state_reg, state_next;
    logic      sel_fwd_reg, sel_fwd_next;
    cnt_t      remain_reg, remain_next;
    page_t     cur_reg, cur_next;

    logic          out_valid_reg, out_valid_next;
    logic [15:0]   out_value_reg, out_value_next;
    status_t       out_status_reg, out_status_next;
    logic          out_last_reg, out_last_next;

    stk_ctrl_t back_ctrl, fwd_ctrl;
    page_t     back_top, fwd_top;
    cnt_t      back_count, fwd_count;

    logic slot_free;
    logic take;
    kind_t kind;

    // the output slot can be refilled when empty or being taken this cycle
    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && slot_free;
    assign take      = req.valid && req.ready;
    assign kind      = kind_t'(req.kind);

    hsn_stack u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (back_ctrl),
        .push_data (cur_reg),
        .top       (back_top),
        .count     (back_count)
    );

    hsn_stack u_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fwd_ctrl),
        .push_data (cur_reg),
        .top       (fwd_top),
        .count     (fwd_count)
    );

    always_comb
    begin
        state_next      = state_reg;
        sel_fwd_next    = sel_fwd_reg;
        remain_next     = remain_reg;
        cur_next        = cur_reg;
        back_ctrl.op    = STK_HOLD;
        fwd_ctrl.op     = STK_HOLD;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_last_next   = 1'b1;
                    case (kind)
                        K_VISIT:
                        begin
                            if (back_count == CNT_W'(DEPTH))
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                back_ctrl.op = STK_PUSH;
                                fwd_ctrl.op  = STK_CLEAR;
                                cur_next     = to_page(req.page);
                            end
                        end
                        K_FORWARD:
                        begin
                            if (fwd_count == '0)
                            begin
                                out_status_next = STAT_EMPTY;
                            end
                            else if (back_count == CNT_W'(DEPTH))
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                back_ctrl.op = STK_PUSH;
                                fwd_ctrl.op  = STK_POP;
                                cur_next     = fwd_top;
                            end
                        end
                        K_BACK:
                        begin
                            if (back_count == '0)
                            begin
                                out_status_next = STAT_EMPTY;
                            end
                            else if (fwd_count == CNT_W'(DEPTH))
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                fwd_ctrl.op  = STK_PUSH;
                                back_ctrl.op = STK_POP;
                                cur_next     = back_top;
                            end
                        end
                        K_LIST_BACK, K_LIST_FWD:
                        begin
                            sel_fwd_next = (kind == K_LIST_FWD);
                            remain_next  = (kind == K_LIST_FWD) ? fwd_count : back_count;
                            if (remain_next == '0)
                            begin
                                out_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                // results come from the listing walk
                                out_valid_next = 1'b0;
                                state_next     = ST_LIST;
                            end
                        end
                        K_READ:
                        begin
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                        end
                    endcase
                    out_value_next = (out_status_next == STAT_EMPTY &&
                                      (kind == K_LIST_BACK || kind == K_LIST_FWD))
                                     ? 16'd0 : to_value(cur_next);
                end
            end
            ST_LIST:
            begin
                if (slot_free)
                begin
                    // emit the top entry and rotate it to the bottom
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_value_next  = to_value(sel_fwd_reg ? fwd_top : back_top);
                    out_last_next   = (remain_reg == CNT_W'(1));
                    if (sel_fwd_reg)
                    begin
                        fwd_ctrl.op = STK_ROT;
                    end
                    else
                    begin
                        back_ctrl.op = STK_ROT;
                    end
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            remain_reg    <= '0;
            sel_fwd_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            remain_reg    <= remain_next;
            sel_fwd_reg   <= sel_fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.value  = out_value_reg;
    assign rsp.status = out_status_reg;
    assign rsp.last   = out_last_reg;

    // a listing walk never runs past the occupied part of its stack
    a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |-> (remain_reg != '0) &&
            (remain_reg <= (sel_fwd_reg ? fwd_count : back_count)))
        else $error("listing counter out of range");

    // neither stack ever holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (back_count <= CNT_W'(DEPTH)) && (fwd_count <= CNT_W'(DEPTH)))
        else $error("stack count above depth");

    // listing an empty back stack gives one empty, final result
    a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
        (take && kind == K_LIST_BACK && back_count == '0) |=>
            (rsp.valid && rsp.status == STAT_EMPTY && rsp.last && state_reg == ST_IDLE))
        else $error("empty listing result wrong");

    // the stacks stay untouched while a result waits in a stalled output
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> ($stable(back_count) && $stable(fwd_count) &&
            $stable(cur_reg)))
        else $error("state moved while output stalled");
endmodule
